// File: rtl/fsb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsb_pkg: shared types and constants for the FAT short-name builder
// Character and name layouts, parse phases and the upcase helper.
// ----------------------------------------------------------------------------
package fsb_pkg;

    localparam int TAIL_COUNTER_BITS = 16;
    // decimal digits needed for the largest counter value
    localparam int TAIL_DIGITS = 5;
    localparam int NAME_BYTES = 11;
    localparam int BASE_BYTES = 8;
    localparam int EXT_BYTES = 3;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [3:0] DIGIT_HIGH = 4'h3;
    localparam logic [3:0] LAST_INDEX = 4'(NAME_BYTES - 1);

    typedef enum logic [1:0] {
        PH_BASE  = 2'd0,
        PH_SKIP  = 2'd1,
        PH_EXT   = 2'd2,
        PH_ENDED = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in;

    typedef struct packed {
        logic [7:0] name_byte;
        logic [3:0] byte_index;
        logic [7:0] name_checksum;
        logic       last_byte;
    } t_out;

    typedef logic [NAME_BYTES-1:0][7:0] t_name;
    typedef logic [TAIL_DIGITS-1:0][3:0] t_bcd;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/fsb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsb_front: character parser
// Takes one name character per transfer, fills the short-name buffer and, on
// the final character, hands the finished 11-byte name to the queue.
// ----------------------------------------------------------------------------
module fsb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire fsb_pkg::t_in  i_in,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output fsb_pkg::t_name     o_q_name
);

    fsb_pkg::t_name  r_buf, n_buf;
    fsb_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_base_cnt, n_base_cnt;
    logic [1:0]      r_ext_cnt, n_ext_cnt;
    logic            r_tail_needed, n_tail_needed;
    logic [1:0]      r_raw_len, n_raw_len;
    logic            r_all_dots, n_all_dots;
    logic [fsb_pkg::TAIL_COUNTER_BITS-1:0] r_tail_bin, n_tail_bin;
    fsb_pkg::t_bcd   r_tail_bcd, n_tail_bcd;

    logic            accept;
    logic            live;
    logic [7:0]      c;
    logic            dot_name;
    logic            use_tail;
    logic [2:0]      tail_len;
    fsb_pkg::t_name  fin_name;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign c          = i_in.char_in;
    assign live       = accept && (r_phase != fsb_pkg::PH_ENDED) && (c != fsb_pkg::CHAR_NUL);

    // phase transitions
    always_comb begin
        n_phase = r_phase;
        if (accept && r_phase != fsb_pkg::PH_ENDED) begin
            if (c == fsb_pkg::CHAR_NUL) begin
                n_phase = fsb_pkg::PH_ENDED;
            end else if (c != fsb_pkg::CHAR_SPACE) begin
                unique case (r_phase)
                    fsb_pkg::PH_BASE: begin
                        if (c == fsb_pkg::CHAR_DOT) begin
                            n_phase = fsb_pkg::PH_EXT;
                        end else if (r_base_cnt == 4'(fsb_pkg::BASE_BYTES)) begin
                            n_phase = fsb_pkg::PH_SKIP;
                        end
                    end
                    fsb_pkg::PH_SKIP: begin
                        if (c == fsb_pkg::CHAR_DOT) begin
                            n_phase = fsb_pkg::PH_EXT;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // buffer and counters
    always_comb begin
        n_buf         = r_buf;
        n_base_cnt    = r_base_cnt;
        n_ext_cnt     = r_ext_cnt;
        n_tail_needed = r_tail_needed;
        n_raw_len     = r_raw_len;
        n_all_dots    = r_all_dots;
        if (live) begin
            if (r_raw_len != 2'd3) begin
                n_raw_len = r_raw_len + 2'd1;
            end
            if (c != fsb_pkg::CHAR_DOT) begin
                n_all_dots = 1'b0;
            end
            if (c != fsb_pkg::CHAR_SPACE) begin
                if (r_phase == fsb_pkg::PH_BASE && c != fsb_pkg::CHAR_DOT) begin
                    if (r_base_cnt < 4'(fsb_pkg::BASE_BYTES)) begin
                        n_buf[r_base_cnt[2:0]] = fsb_pkg::upcase(c);
                        n_base_cnt = r_base_cnt + 4'd1;
                    end else begin
                        n_tail_needed = 1'b1;
                    end
                end else if (r_phase == fsb_pkg::PH_EXT) begin
                    if (r_ext_cnt != 2'(fsb_pkg::EXT_BYTES)) begin
                        n_buf[{2'b10, r_ext_cnt}] = fsb_pkg::upcase(c);
                        n_ext_cnt = r_ext_cnt + 2'd1;
                    end
                end
            end
        end
    end

    // significant decimal digits of the tail counter
    always_comb begin
        tail_len = 3'd1;
        for (int k = 1; k < fsb_pkg::TAIL_DIGITS; k++) begin
            if (r_tail_bcd[k] != 4'd0) begin
                tail_len = 3'(k + 1);
            end
        end
    end

    assign dot_name = n_all_dots && (n_raw_len == 2'd1 || n_raw_len == 2'd2);
    assign use_tail = n_tail_needed && !dot_name;

    // finished name: dot names replace the buffer, long bases get the ~N tail
    always_comb begin
        fin_name = n_buf;
        if (dot_name) begin
            fin_name    = {fsb_pkg::NAME_BYTES{fsb_pkg::CHAR_SPACE}};
            fin_name[0] = fsb_pkg::CHAR_DOT;
            if (n_raw_len == 2'd2) begin
                fin_name[1] = fsb_pkg::CHAR_DOT;
            end
        end else if (n_tail_needed) begin
            for (int k = 0; k < fsb_pkg::TAIL_DIGITS; k++) begin
                if (3'(k) < tail_len) begin
                    fin_name[fsb_pkg::BASE_BYTES-1-k] = {fsb_pkg::DIGIT_HIGH, r_tail_bcd[k]};
                end
            end
            fin_name[{1'b0, 3'(fsb_pkg::BASE_BYTES - 1) - tail_len}] = fsb_pkg::CHAR_TILDE;
        end
    end

    // decimal shadow of the tail counter, cleared when the binary count wraps
    always_comb begin
        logic carry;
        n_tail_bin = r_tail_bin;
        n_tail_bcd = r_tail_bcd;
        carry      = 1'b1;
        if (o_q_push && use_tail) begin
            n_tail_bin = r_tail_bin + {{(fsb_pkg::TAIL_COUNTER_BITS-1){1'b0}}, 1'b1};
            if (&r_tail_bin) begin
                n_tail_bcd = '0;
            end else begin
                for (int k = 0; k < fsb_pkg::TAIL_DIGITS; k++) begin
                    if (carry) begin
                        if (r_tail_bcd[k] == 4'd9) begin
                            n_tail_bcd[k] = 4'd0;
                        end else begin
                            n_tail_bcd[k] = r_tail_bcd[k] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
        end
    end

    assign o_q_push = accept && i_in.last_char;
    assign o_q_name = fin_name;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf         <= {fsb_pkg::NAME_BYTES{fsb_pkg::CHAR_SPACE}};
            r_phase       <= fsb_pkg::PH_BASE;
            r_base_cnt    <= '0;
            r_ext_cnt     <= '0;
            r_tail_needed <= 1'b0;
            r_raw_len     <= '0;
            r_all_dots    <= 1'b1;
            r_tail_bin    <= '0;
            r_tail_bcd    <= '0;
        end else begin
            r_tail_bin <= n_tail_bin;
            r_tail_bcd <= n_tail_bcd;
            if (o_q_push) begin
                // refill for the next name
                r_buf         <= {fsb_pkg::NAME_BYTES{fsb_pkg::CHAR_SPACE}};
                r_phase       <= fsb_pkg::PH_BASE;
                r_base_cnt    <= '0;
                r_ext_cnt     <= '0;
                r_tail_needed <= 1'b0;
                r_raw_len     <= '0;
                r_all_dots    <= 1'b1;
            end else begin
                r_buf         <= n_buf;
                r_phase       <= n_phase;
                r_base_cnt    <= n_base_cnt;
                r_ext_cnt     <= n_ext_cnt;
                r_tail_needed <= n_tail_needed;
                r_raw_len     <= n_raw_len;
                r_all_dots    <= n_all_dots;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/fsb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsb_queue: two-entry name queue
// Holds finished names between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module fsb_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fsb_pkg::t_name  i_name,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output fsb_pkg::t_name       o_name
);

    fsb_pkg::t_name r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count, n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_name  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/fsb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsb_back: byte emitter
// Takes a finished name from the queue and sends its 11 bytes out one per
// transfer, accumulating the long-name checksum on the way.
// ----------------------------------------------------------------------------
module fsb_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire fsb_pkg::t_name  i_q_name,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output fsb_pkg::t_out        o_out
);

    logic           r_busy;
    fsb_pkg::t_name r_name;
    logic [3:0]     r_idx;
    logic [7:0]     r_sum;
    logic           r_out_valid;
    fsb_pkg::t_out  r_out;

    logic           step;
    logic           last;
    logic [7:0]     sum_next;

    assign o_q_pop  = !r_busy && i_q_valid;
    assign step     = r_busy && (!r_out_valid || !i_out_stall);
    assign last     = (r_idx == fsb_pkg::LAST_INDEX);
    assign sum_next = {r_sum[0], r_sum[7:1]} + r_name[0];

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.name_byte     <= r_name[0];
            r_out.byte_index    <= r_idx;
            r_out.name_checksum <= last ? sum_next : 8'h00;
            r_out.last_byte     <= last;
        end
        if (o_q_pop) begin
            r_name <= i_q_name;
            r_idx  <= '0;
            r_sum  <= '0;
        end else if (step) begin
            // advance to the next byte
            r_name <= {fsb_pkg::CHAR_SPACE, r_name[fsb_pkg::NAME_BYTES-1:1]};
            r_idx  <= r_idx + 4'd1;
            r_sum  <= sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (step && last) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/fat_short_name_builder.sv
`default_nettype none
// Output: a name passes the name queue, the emitter's name register and its output
// register; the 11 bytes go out one per cycle while the output is not stalled.
// Throughput: one character per cycle in unless the queue is full; the emitter takes
// a name only once the last byte is out; two queue entries let parsing run ahead.
// Reset: synchronous, active low; clears the parse state, the buffer to spaces,
// the tail counter and the queue.
// ----------------------------------------------------------------------------
// fat_short_name_builder: FAT 8.3 short name with long-name checksum
// Parser front end, name queue and byte emitter.
// ----------------------------------------------------------------------------
module fat_short_name_builder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire fsb_pkg::t_in   i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output fsb_pkg::t_out       o_out
);

    logic           q_full;
    logic           q_push;
    fsb_pkg::t_name q_wr_name;
    logic           q_pop;
    logic           q_valid;
    fsb_pkg::t_name q_rd_name;

    fsb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_name   (q_wr_name)
    );

    fsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_name  (q_wr_name),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_name  (q_rd_name)
    );

    fsb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_name    (q_rd_name),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.last_byte |-> o_out.byte_index == fsb_pkg::LAST_INDEX)
        else $error("last byte not at final index");

    a_sum_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last_byte |-> o_out.name_checksum == 8'h00)
        else $error("checksum on a non-final byte");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out.last_byte |=>
            o_out_valid && o_out.byte_index == 4'($past(o_out.byte_index) + 4'd1))
        else $error("byte index did not advance");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("name pushed into full queue");

endmodule
`default_nettype wire
